// File: sv/rej_pkg.sv
// ----------------------------------------------------------------------------
// rej_pkg
// Types, constants and helper functions of the reprojection error block.
// ----------------------------------------------------------------------------
package rej_pkg;

  localparam int unsigned POSE_WORDS = 12;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned RAM_DEPTH  = 64;
  localparam int unsigned PC_W       = 7;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X  = 3'd0,
    CFG_FOCAL_Y  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_ERR  = 2'd0,
    KIND_PJAC = 2'd1,
    KIND_XJAC = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    OP_LD, OP_MUL, OP_ADD, OP_SUB, OP_NEG, OP_DIV, OP_EMIT, OP_BRPM, OP_END
  } op_t;

  typedef enum logic [1:0] {
    LAST_NO, LAST_NOPM, LAST_YES
  } lastsel_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_DIV
  } state_t;

  typedef struct packed {
    logic              is_edge;
    logic [3:0]        pose_index;
    logic signed [31:0] pose_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] meas_u;
    logic signed [31:0] meas_v;
    logic              point_mode;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               depth_flag;
    logic               last;
  } result_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    kind_t             kind;
    logic              row;
    logic [2:0]        col;
    lastsel_t          lst;
  } uinst_t;

  // Scratch memory map. Words 0 to 11 hold the pose.
  localparam logic [ADDR_W-1:0] A_T0   = 6'd9;
  localparam logic [ADDR_W-1:0] A_PX   = 6'd12;
  localparam logic [ADDR_W-1:0] A_PY   = 6'd13;
  localparam logic [ADDR_W-1:0] A_PZ   = 6'd14;
  localparam logic [ADDR_W-1:0] A_MU   = 6'd15;
  localparam logic [ADDR_W-1:0] A_MV   = 6'd16;
  localparam logic [ADDR_W-1:0] A_FX   = 6'd17;
  localparam logic [ADDR_W-1:0] A_FY   = 6'd18;
  localparam logic [ADDR_W-1:0] A_CX   = 6'd19;
  localparam logic [ADDR_W-1:0] A_CY   = 6'd20;
  localparam logic [ADDR_W-1:0] A_ONE  = 6'd21;
  localparam logic [ADDR_W-1:0] A_ZERO = 6'd22;
  localparam logic [ADDR_W-1:0] A_M    = 6'd23;
  localparam logic [ADDR_W-1:0] A_S    = 6'd24;
  localparam logic [ADDR_W-1:0] A_X    = 6'd25;
  localparam logic [ADDR_W-1:0] A_Y    = 6'd26;
  localparam logic [ADDR_W-1:0] A_Z    = 6'd27;
  localparam logic [ADDR_W-1:0] A_XZ   = 6'd28;
  localparam logic [ADDR_W-1:0] A_YZ   = 6'd29;
  localparam logic [ADDR_W-1:0] A_IZ   = 6'd30;
  localparam logic [ADDR_W-1:0] A_T1   = 6'd31;
  localparam logic [ADDR_W-1:0] A_T2   = 6'd32;
  localparam logic [ADDR_W-1:0] A_T3   = 6'd33;
  localparam logic [ADDR_W-1:0] A_TMP  = 6'd34;
  localparam logic [ADDR_W-1:0] A_EU   = 6'd35;
  localparam logic [ADDR_W-1:0] A_EV   = 6'd36;
  localparam logic [ADDR_W-1:0] A_J00  = 6'd37;
  localparam logic [ADDR_W-1:0] A_J02  = 6'd39;
  localparam logic [ADDR_W-1:0] A_J03  = 6'd40;
  localparam logic [ADDR_W-1:0] A_J04  = 6'd41;
  localparam logic [ADDR_W-1:0] A_J05  = 6'd42;
  localparam logic [ADDR_W-1:0] A_J11  = 6'd44;
  localparam logic [ADDR_W-1:0] A_J12  = 6'd45;
  localparam logic [ADDR_W-1:0] A_J13  = 6'd46;
  localparam logic [ADDR_W-1:0] A_J14  = 6'd47;
  localparam logic [ADDR_W-1:0] A_J15  = 6'd48;
  localparam logic [ADDR_W-1:0] A_PT   = 6'd49;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (!v[33] && (|v[32:31])) return Q_MAX;
    if (v[33] && !(&v[32:31])) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (!v[63] && (|v[62:31])) return Q_MAX;
    if (v[63] && !(&v[62:31])) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat34(34'(a) - 34'(b));
  endfunction

  function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
    return sat34(34'sd0 - 34'(a));
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input int unsigned frac);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> frac);
  endfunction

  function automatic uinst_t mk(input op_t op, input logic [ADDR_W-1:0] dst,
                                input logic [ADDR_W-1:0] a,
                                input logic [ADDR_W-1:0] b);
    uinst_t u;
    u.op   = op;
    u.dst  = dst;
    u.a    = a;
    u.b    = b;
    u.kind = KIND_ERR;
    u.row  = 1'b0;
    u.col  = 3'd0;
    u.lst  = LAST_NO;
    return u;
  endfunction

  function automatic uinst_t em(input logic [ADDR_W-1:0] a, input kind_t kind,
                                input logic row, input logic [2:0] col,
                                input lastsel_t lst);
    uinst_t u;
    u      = mk(OP_EMIT, A_ZERO, a, A_ZERO);
    u.kind = kind;
    u.row  = row;
    u.col  = col;
    u.lst  = lst;
    return u;
  endfunction

  // One step of a point Jacobian entry: (J0*R0c + J1*R1c) + J2*R2c.
  function automatic uinst_t pt_step(input int unsigned s, input int unsigned r,
                                     input int unsigned c);
    logic [ADDR_W-1:0] j0;
    logic [ADDR_W-1:0] j1;
    logic [ADDR_W-1:0] j2;
    logic [ADDR_W-1:0] rc;
    uinst_t u;
    j0 = (r == 0) ? A_J00 : A_ZERO;
    j1 = (r == 0) ? A_ZERO : A_J11;
    j2 = (r == 0) ? A_J02 : A_J12;
    rc = ADDR_W'(c);
    case (s)
      0: u = mk(OP_MUL, A_M, j0, rc);
      1: u = mk(OP_MUL, A_S, j1, rc + 6'd3);
      2: u = mk(OP_ADD, A_S, A_M, A_S);
      3: u = mk(OP_MUL, A_M, j2, rc + 6'd6);
      4: u = mk(OP_ADD, A_PT, A_S, A_M);
      default: u = em(A_PT, KIND_XJAC, r[0], 3'(c),
                      (r == 1 && c == 2) ? LAST_YES : LAST_NO);
    endcase
    return u;
  endfunction

  function automatic uinst_t prog(input logic [PC_W-1:0] pc);
    uinst_t u;
    u = mk(OP_END, A_ZERO, A_ZERO, A_ZERO);
    case (pc)
      7'd0:  u = mk(OP_LD, A_PX, A_ZERO, A_ZERO);
      7'd1:  u = mk(OP_LD, A_PY, A_ZERO, A_ZERO);
      7'd2:  u = mk(OP_LD, A_PZ, A_ZERO, A_ZERO);
      7'd3:  u = mk(OP_LD, A_MU, A_ZERO, A_ZERO);
      7'd4:  u = mk(OP_LD, A_MV, A_ZERO, A_ZERO);
      7'd5:  u = mk(OP_LD, A_FX, A_ZERO, A_ZERO);
      7'd6:  u = mk(OP_LD, A_FY, A_ZERO, A_ZERO);
      7'd7:  u = mk(OP_LD, A_CX, A_ZERO, A_ZERO);
      7'd8:  u = mk(OP_LD, A_CY, A_ZERO, A_ZERO);
      7'd9:  u = mk(OP_LD, A_ONE, A_ZERO, A_ZERO);
      7'd10: u = mk(OP_LD, A_ZERO, A_ZERO, A_ZERO);
      7'd11: u = mk(OP_MUL, A_M, 6'd0, A_PX);
      7'd12: u = mk(OP_MUL, A_S, 6'd1, A_PY);
      7'd13: u = mk(OP_ADD, A_S, A_M, A_S);
      7'd14: u = mk(OP_MUL, A_M, 6'd2, A_PZ);
      7'd15: u = mk(OP_ADD, A_S, A_S, A_M);
      7'd16: u = mk(OP_ADD, A_X, A_S, A_T0);
      7'd17: u = mk(OP_MUL, A_M, 6'd3, A_PX);
      7'd18: u = mk(OP_MUL, A_S, 6'd4, A_PY);
      7'd19: u = mk(OP_ADD, A_S, A_M, A_S);
      7'd20: u = mk(OP_MUL, A_M, 6'd5, A_PZ);
      7'd21: u = mk(OP_ADD, A_S, A_S, A_M);
      7'd22: u = mk(OP_ADD, A_Y, A_S, 6'd10);
      7'd23: u = mk(OP_MUL, A_M, 6'd6, A_PX);
      7'd24: u = mk(OP_MUL, A_S, 6'd7, A_PY);
      7'd25: u = mk(OP_ADD, A_S, A_M, A_S);
      7'd26: u = mk(OP_MUL, A_M, 6'd8, A_PZ);
      7'd27: u = mk(OP_ADD, A_S, A_S, A_M);
      7'd28: u = mk(OP_ADD, A_Z, A_S, 6'd11);
      7'd29: u = mk(OP_DIV, A_XZ, A_X, A_Z);
      7'd30: u = mk(OP_DIV, A_YZ, A_Y, A_Z);
      7'd31: u = mk(OP_DIV, A_IZ, A_ONE, A_Z);
      7'd32: u = mk(OP_MUL, A_T1, A_FX, A_XZ);
      7'd33: u = mk(OP_ADD, A_TMP, A_T1, A_CX);
      7'd34: u = mk(OP_SUB, A_EU, A_MU, A_TMP);
      7'd35: u = mk(OP_MUL, A_T2, A_FY, A_YZ);
      7'd36: u = mk(OP_ADD, A_TMP, A_T2, A_CY);
      7'd37: u = mk(OP_SUB, A_EV, A_MV, A_TMP);
      7'd38: u = mk(OP_MUL, A_TMP, A_FX, A_IZ);
      7'd39: u = mk(OP_NEG, A_J00, A_TMP, A_ZERO);
      7'd40: u = mk(OP_MUL, A_J02, A_T1, A_IZ);
      7'd41: u = mk(OP_MUL, A_J03, A_T1, A_YZ);
      7'd42: u = mk(OP_NEG, A_TMP, A_FX, A_ZERO);
      7'd43: u = mk(OP_MUL, A_M, A_T1, A_XZ);
      7'd44: u = mk(OP_SUB, A_J04, A_TMP, A_M);
      7'd45: u = mk(OP_MUL, A_J05, A_FX, A_YZ);
      7'd46: u = mk(OP_MUL, A_TMP, A_FY, A_IZ);
      7'd47: u = mk(OP_NEG, A_J11, A_TMP, A_ZERO);
      7'd48: u = mk(OP_MUL, A_J12, A_T2, A_IZ);
      7'd49: u = mk(OP_MUL, A_TMP, A_T2, A_YZ);
      7'd50: u = mk(OP_ADD, A_J13, A_FY, A_TMP);
      7'd51: u = mk(OP_MUL, A_T3, A_FY, A_XZ);
      7'd52: u = mk(OP_MUL, A_TMP, A_T3, A_YZ);
      7'd53: u = mk(OP_NEG, A_J14, A_TMP, A_ZERO);
      7'd54: u = mk(OP_NEG, A_J15, A_T3, A_ZERO);
      7'd55: u = em(A_EU, KIND_ERR, 1'b0, 3'd0, LAST_NO);
      7'd56: u = em(A_EV, KIND_ERR, 1'b1, 3'd0, LAST_NO);
      7'd57: u = em(A_J00, KIND_PJAC, 1'b0, 3'd0, LAST_NO);
      7'd58: u = em(A_ZERO, KIND_PJAC, 1'b0, 3'd1, LAST_NO);
      7'd59: u = em(A_J02, KIND_PJAC, 1'b0, 3'd2, LAST_NO);
      7'd60: u = em(A_J03, KIND_PJAC, 1'b0, 3'd3, LAST_NO);
      7'd61: u = em(A_J04, KIND_PJAC, 1'b0, 3'd4, LAST_NO);
      7'd62: u = em(A_J05, KIND_PJAC, 1'b0, 3'd5, LAST_NO);
      7'd63: u = em(A_ZERO, KIND_PJAC, 1'b1, 3'd0, LAST_NO);
      7'd64: u = em(A_J11, KIND_PJAC, 1'b1, 3'd1, LAST_NO);
      7'd65: u = em(A_J12, KIND_PJAC, 1'b1, 3'd2, LAST_NO);
      7'd66: u = em(A_J13, KIND_PJAC, 1'b1, 3'd3, LAST_NO);
      7'd67: u = em(A_J14, KIND_PJAC, 1'b1, 3'd4, LAST_NO);
      7'd68: u = em(A_J15, KIND_PJAC, 1'b1, 3'd5, LAST_NOPM);
      7'd69: u = mk(OP_BRPM, A_ZERO, A_ZERO, A_ZERO);
      default: begin
        for (int blk = 0; blk < 6; blk++) begin
          for (int s = 0; s < 6; s++) begin
            if (int'(pc) == 70 + blk * 6 + s) begin
              u = pt_step(s, blk / 3, blk % 3);
            end
          end
        end
      end
    endcase
    return u;
  endfunction

endpackage

// File: sv/rej_ram.sv
// ----------------------------------------------------------------------------
// rej_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rej_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: sv/rej_div.sv
// ----------------------------------------------------------------------------
// rej_div
// Bit-serial fixed-point divider, (a << FRAC_BITS) / b, truncated, saturated.
// ----------------------------------------------------------------------------
module rej_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] res
);

  import rej_pkg::*;

  localparam int N  = 32 + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [N-1:0]  dvd;
  logic [N-1:0]  quo;
  logic [31:0]   rem;
  logic [31:0]   nb;
  logic          neg;
  logic [31:0]   a_abs;
  logic [31:0]   b_abs;
  logic [32:0]   trial;
  logic signed [31:0] fin;

  assign a_abs = a[31] ? 32'(-a) : 32'(a);
  assign b_abs = b[31] ? 32'(-b) : 32'(b);
  assign trial = {rem, dvd[N-1]};

  always_comb begin
    if (!neg) begin
      fin = (|quo[N-1:31]) ? Q_MAX : quo[31:0];
    end else if ((|quo[N-1:32]) || (quo[31] && (|quo[30:0]))) begin
      fin = Q_MIN;
    end else begin
      fin = 32'(-quo[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (b == 32'sd0) begin
          res  <= (a > 32'sd0) ? Q_MAX : ((a < 32'sd0) ? Q_MIN : 32'sd0);
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CW'(N);
          dvd  <= {a_abs, {FRAC_BITS{1'b0}}};
          quo  <= '0;
          rem  <= '0;
          nb   <= b_abs;
          neg  <= a[31] ^ b[31];
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          res  <= fin;
        end else begin
          cnt <= cnt - 1'b1;
          dvd <= {dvd[N-2:0], 1'b0};
          if (trial >= {1'b0, nb}) begin
            rem <= 32'(trial - {1'b0, nb});
            quo <= {quo[N-2:0], 1'b1};
          end else begin
            rem <= trial[31:0];
            quo <= {quo[N-2:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

// File: sv/rej_front.sv
// ----------------------------------------------------------------------------
// rej_front
// Input stage: takes items, drops pose writes to no word, queues the rest.
// ----------------------------------------------------------------------------
module rej_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  rej_pkg::item_t item_in,
  output logic           q_valid,
  output rej_pkg::item_t q_item,
  input  logic           q_pop
);

  import rej_pkg::*;

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       enq;
  logic       deq;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_item  = slots[rp];
  assign enq     = push && !full &&
                   (item_in.is_edge || (item_in.pose_index < 4'(POSE_WORDS)));
  assign deq     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wp] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) begin
        wp <= !wp;
      end
      if (deq) begin
        rp <= !rp;
      end
      cnt <= cnt + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

// File: sv/rej_back.sv
// ----------------------------------------------------------------------------
// rej_back
// Execution stage: a sequencer over a scratch RAM, one multiplier, one adder
// and a serial divider, feeding a two-entry result queue.
// ----------------------------------------------------------------------------
module rej_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rej_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic [30:0]        focal_x,
  input  logic [30:0]        focal_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  output logic               res_empty,
  input  logic               res_pop,
  output rej_pkg::result_t   res_head
);

  import rej_pkg::*;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  state_t            state;
  state_t            state_next;
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  uinst_t            ui;
  item_t             item_r;
  logic              flag_r;
  logic [POSE_WORDS-1:0] pose_valid;
  logic              mask_a;
  logic              mask_b;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic              ram_re;
  logic [31:0]       rd_a;
  logic [31:0]       rd_b;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [31:0] alu;
  logic signed [31:0] ld_val;

  logic              div_start;
  logic              div_done;
  logic signed [31:0] div_res;

  result_t           oq [2];
  logic              owp;
  logic              orp;
  logic [1:0]        ocnt;
  logic              out_full;
  logic              out_push;
  logic              out_pop;
  result_t           res_new;

  assign ui = prog(pc);

  rej_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ui.a),
    .raddr_b (ui.b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  rej_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (opa),
    .b     (opb),
    .done  (div_done),
    .res   (div_res)
  );

  assign opa = mask_a ? 32'sd0 : rd_a;
  assign opb = mask_b ? 32'sd0 : rd_b;

  always_comb begin
    case (ui.dst)
      A_PX:    ld_val = item_r.point_x;
      A_PY:    ld_val = item_r.point_y;
      A_PZ:    ld_val = item_r.point_z;
      A_MU:    ld_val = item_r.meas_u;
      A_MV:    ld_val = item_r.meas_v;
      A_FX:    ld_val = {1'b0, focal_x};
      A_FY:    ld_val = {1'b0, focal_y};
      A_CX:    ld_val = center_x;
      A_CY:    ld_val = center_y;
      A_ONE:   ld_val = ONE;
      default: ld_val = 32'sd0;
    endcase
  end

  always_comb begin
    case (ui.op)
      OP_LD:   alu = ld_val;
      OP_MUL:  alu = qmul(opa, opb, FRAC_BITS);
      OP_ADD:  alu = qadd(opa, opb);
      OP_SUB:  alu = qsub(opa, opb);
      OP_NEG:  alu = qneg(opa);
      default: alu = div_res;
    endcase
  end

  assign out_full = (ocnt == 2'd2);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_item.is_edge) begin
          state_next = ST_FETCH;
          pc_next    = '0;
        end
      end
      ST_FETCH: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (ui.op)
          OP_DIV: state_next = ST_DIV;
          OP_EMIT: begin
            if (!out_full) begin
              state_next = ST_FETCH;
              pc_next    = pc + 1'b1;
            end
          end
          OP_BRPM: begin
            state_next = item_r.point_mode ? ST_FETCH : ST_IDLE;
            pc_next    = pc + 1'b1;
          end
          OP_END: state_next = ST_IDLE;
          default: begin
            state_next = ST_FETCH;
            pc_next    = pc + 1'b1;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FETCH;
          pc_next    = pc + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ui.dst;
    ram_wdata = alu;
    ram_re    = 1'b0;
    div_start = 1'b0;
    out_push  = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop     = q_valid;
        ram_we    = q_valid && !q_item.is_edge;
        ram_waddr = ADDR_W'(q_item.pose_index);
        ram_wdata = q_item.pose_value;
      end
      ST_FETCH: ram_re = 1'b1;
      ST_EXEC: begin
        case (ui.op)
          OP_LD, OP_MUL, OP_ADD, OP_SUB, OP_NEG: ram_we = 1'b1;
          OP_DIV:  div_start = 1'b1;
          OP_EMIT: out_push = !out_full;
          default: ram_we = 1'b0;
        endcase
      end
      ST_DIV: ram_we = div_done;
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      pose_valid <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (state == ST_IDLE && q_valid && !q_item.is_edge) begin
        pose_valid[q_item.pose_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_item.is_edge) begin
      item_r <= q_item;
    end
    if (state == ST_FETCH) begin
      mask_a <= (ui.a < ADDR_W'(POSE_WORDS)) && !pose_valid[ui.a[3:0]];
      mask_b <= (ui.b < ADDR_W'(POSE_WORDS)) && !pose_valid[ui.b[3:0]];
    end
    if (div_start) begin
      flag_r <= (opb == 32'sd0);
    end
  end

  always_comb begin
    res_new.kind       = ui.kind;
    res_new.row        = ui.row;
    res_new.col        = ui.col;
    res_new.value      = opa;
    res_new.depth_flag = flag_r;
    res_new.last       = (ui.lst == LAST_YES) ||
                         ((ui.lst == LAST_NOPM) && !item_r.point_mode);
  end

  assign res_empty = (ocnt == 2'd0);
  assign res_head  = oq[orp];
  assign out_pop   = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq[owp] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (out_push) begin
        owp <= !owp;
      end
      if (out_pop) begin
        orp <= !orp;
      end
      ocnt <= ocnt + {1'b0, out_push} - {1'b0, out_pop};
    end
  end

endmodule

// File: sv/reprojection_error_jacobian.sv
// ----------------------------------------------------------------------------
// reprojection_error_jacobian
// Pinhole reprojection error with SE(3) pose and point Jacobians, fixed point.
// ----------------------------------------------------------------------------
// Items enter through a queue interface (push/full). A pose-write item loads
// one of twelve pose words; an edge item yields 14 results, or 20 in point
// mode, read through a second queue interface (empty/pop) in a fixed order
// with last set on the final result of the edge.
// Edge items wait in a two-entry input queue while a sequencer works through
// a microprogram on a scratch RAM, fetching the operands of each operation
// and then executing it; the three divisions run in the serial divider. The
// back end works on one edge at a time and takes a new item from the input
// queue only while idle.
// Configuration registers are written through cfg_valid/cfg_ready, which is
// always ready; the user must write them only while the block is idle, as
// the block itself does not enforce it.
// Reset clears both queues, the sequencer and the pose, and sets unit focal
// lengths and a zero principal point. When the receiver stops popping, the
// two-entry result queue fills, the sequencer holds, and then the input
// queue fills and full rises.
// ----------------------------------------------------------------------------
module reprojection_error_jacobian #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             func,
  input  logic [3:0]                       pose_index,
  input  logic signed [31:0]               pose_value,
  input  logic signed [31:0]               point_x,
  input  logic signed [31:0]               point_y,
  input  logic signed [31:0]               point_z,
  input  logic signed [31:0]               meas_u,
  input  logic signed [31:0]               meas_v,
  input  logic                             point_mode,
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       kind,
  output logic                             row,
  output logic [2:0]                       col,
  output logic signed [31:0]               value,
  output logic                             depth_flag,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rej_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);

  import rej_pkg::*;

  logic [30:0]        focal_x;
  logic [30:0]        focal_y;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  item_t              item_in;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;
  result_t            res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= 31'(64'(1) << FRAC_BITS);
      focal_y  <= 31'(64'(1) << FRAC_BITS);
      center_x <= 32'sd0;
      center_y <= 32'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FOCAL_X:  focal_x  <= cfg_data[30:0];
        CFG_FOCAL_Y:  focal_y  <= cfg_data[30:0];
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        default:      focal_x  <= focal_x;
      endcase
    end
  end

  always_comb begin
    item_in.is_edge    = func;
    item_in.pose_index = pose_index;
    item_in.pose_value = pose_value;
    item_in.point_x    = point_x;
    item_in.point_y    = point_y;
    item_in.point_z    = point_z;
    item_in.meas_u     = meas_u;
    item_in.meas_v     = meas_v;
    item_in.point_mode = point_mode;
  end

  rej_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item_in (item_in),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rej_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .focal_x   (focal_x),
    .focal_y   (focal_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .res_empty (empty),
    .res_pop   (pop),
    .res_head  (res_head)
  );

  assign kind       = res_head.kind;
  assign row        = res_head.row;
  assign col        = res_head.col;
  assign value      = res_head.value;
  assign depth_flag = res_head.depth_flag;
  assign last       = res_head.last;

  // Only a pose or point Jacobian entry can close an edge.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (kind == KIND_PJAC || kind == KIND_XJAC))
    else $error("last set on an error term");

  // Error terms always sit in column zero.
  a_err_col: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_ERR) |-> (col == 3'd0))
    else $error("error term with nonzero column");

  // Point Jacobian entries only use the first three columns.
  a_xjac_col: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_XJAC) |-> (col == 3'd0 || col == 3'd1 || col == 3'd2))
    else $error("point Jacobian column out of range");

endmodule
